FILE: hdl/salru_pkg.sv
package salru_pkg;

	localparam int STAMP_W = 32;
	localparam int PENALTY_W = 16;
	localparam int ADDED_W = 18;

	localparam logic [PENALTY_W-1:0] MISS_PENALTY_RST = 16'd30;
	localparam logic [ADDED_W-1:0] WRITEBACK_COST = 18'd2;

	localparam logic [ADDED_W-1:0] ADDER_B32 = 18'd2;
	localparam logic [ADDED_W-1:0] ADDER_B64 = 18'd6;
	localparam logic [ADDED_W-1:0] ADDER_B128 = 18'd12;

	// floor of log2, 0 for values below 2
	function automatic int floor_log2(input int v);
		int n;
		int x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x / 2;
			n = n + 1;
		end
		return n;
	endfunction

	function automatic logic [ADDED_W-1:0] block_adder(input int bytes);
		logic [ADDED_W-1:0] r;
		r = '0;
		if (bytes == 32) r = ADDER_B32;
		if (bytes == 64) r = ADDER_B64;
		if (bytes == 128) r = ADDER_B128;
		return r;
	endfunction

endpackage

FILE: hdl/salru_ram.sv
module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/salru_victim.sv
module salru_victim import salru_pkg::*; #(
	parameter int WAYS = 2,
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  logic [WAYS-1:0][STAMP_W-1:0] stamps,
	output logic [WAY_W-1:0]             victim
);

	localparam int NP = 2 ** $clog2(WAYS);

	logic [STAMP_W-1:0] st [2*NP];
	logic [WAY_W-1:0]   id [2*NP];
	logic               pr [2*NP];

	// tournament over the stamps; left wins ties so the lowest way is chosen
	always_comb begin
		for (int i = 0; i < 2 * NP; i++) begin
			st[i] = '1;
			id[i] = '0;
			pr[i] = 1'b0;
		end
		for (int i = 0; i < NP; i++) begin
			if (i < WAYS) begin
				st[NP+i] = stamps[i];
				id[NP+i] = WAY_W'(i);
				pr[NP+i] = 1'b1;
			end
		end
		for (int i = NP - 1; i >= 1; i--) begin
			if (pr[2*i+1] && (st[2*i+1] < st[2*i])) begin
				st[i] = st[2*i+1];
				id[i] = id[2*i+1];
			end else begin
				st[i] = st[2*i];
				id[i] = id[2*i];
			end
			pr[i] = pr[2*i] | pr[2*i+1];
		end
	end

	assign victim = id[1];

endmodule

FILE: hdl/set_assoc_lru_writeback_cache_unit.sv
// Set-associative cache timing model with LRU replacement, write-back and
// write-allocate. Each accepted access is looked up in a single-port-per-side
// tag RAM holding one set per row (valid, dirty, tag and use stamp of every
// way); the row is read at accept and written back when the result is loaded
// into the output register. One access is taken per cycle while the output is
// not stalled, set by that one-row read-modify-write; the result passes through
// the lookup stage register and then the output register. An access to the set
// being written back in the same cycle gets the new row by forwarding. After
// reset a clearing pass writes every row, 2**floor(log2(SETS)) rows (512 at the
// default geometry), during which in_stall is high. The miss penalty register
// (cfg_penalty) may be written at any time the block is idle.
module set_assoc_lru_writeback_cache_unit import salru_pkg::*; #(
	parameter int WAYS = 2,
	parameter int BLOCK_BYTES = 32,
	parameter int SETS = 512,
	parameter int ADDR_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [PENALTY_W-1:0] cfg_penalty,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [31:0]          address,
	input  logic [15:0]          instr_count,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic                 way_used,
	output logic                 dirty_eviction,
	output logic [ADDED_W-1:0]   cycles_added,
	output logic [47:0]          total_cycles,
	output logic [31:0]          total_instructions,
	output logic [31:0]          access_total,
	output logic [31:0]          miss_total
);

	localparam int OB = floor_log2(BLOCK_BYTES);
	localparam int IB = floor_log2(SETS);
	localparam int ROWS = 2 ** IB;
	localparam int IDX_W = (IB > 0) ? IB : 1;
	localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int TAG_RAW = AW - OB - IB;
	localparam int TAG_W = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [32:0] AMASK_W = (33'd1 << AW) - 33'd1;
	localparam logic [31:0] AMASK = AMASK_W[31:0];
	localparam logic [31:0] IDX_MASK = 32'(ROWS) - 32'd1;
	localparam logic [ADDED_W-1:0] BLOCK_ADD = block_adder(BLOCK_BYTES);

	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	// config and running state
	logic [PENALTY_W-1:0] penalty_q;
	logic [STAMP_W-1:0]   use_stamp_q;
	logic [47:0]          cycle_sum_q;
	logic [31:0]          instr_sum_q;
	logic [31:0]          access_sum_q;
	logic [31:0]          miss_sum_q;

	logic                 clearing_q;
	logic [IDX_W-1:0]     clr_idx_q;

	// lookup stage
	logic                 valid_s1;
	logic                 func_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic [15:0]          icount_s1;
	logic                 fwd_s1;
	row_t                 fwd_row_s1;

	// output register
	logic                 out_valid_q;
	logic                 hit_q;
	logic                 way_q;
	logic                 dev_q;
	logic [ADDED_W-1:0]   added_q;

	logic                 in_accept;
	logic                 out_free;
	logic                 s1_fire;
	logic [31:0]          addr_m;
	logic [31:0]          idx_full;
	logic [31:0]          tag_full;
	logic [IDX_W-1:0]     in_idx;
	logic [TAG_W-1:0]     in_tag;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [ROW_W-1:0]     ram_wdata;
	logic [ROW_W-1:0]     ram_rdata;

	row_t                 cur_row;
	row_t                 wr_row;
	logic [WAYS-1:0][STAMP_W-1:0] stamps;
	logic [WAY_W-1:0]     victim;
	logic                 lk_hit;
	logic [WAY_W-1:0]     hit_way;
	logic                 inv_any;
	logic [WAY_W-1:0]     inv_way;
	logic [WAY_W-1:0]     sel_way;
	logic                 dirty_ev;
	logic [STAMP_W-1:0]   stamp_nx;
	logic [ADDED_W-1:0]   added;

	assign cfg_ready = 1'b1;

	assign out_free  = !out_valid_q || !out_stall;
	assign s1_fire   = valid_s1 && out_free;
	assign in_stall  = clearing_q || (valid_s1 && !out_free);
	assign in_accept = in_valid && !in_stall;

	assign addr_m   = address & AMASK;
	assign idx_full = (addr_m >> OB) & IDX_MASK;
	assign tag_full = addr_m >> (OB + IB);
	assign in_idx   = idx_full[IDX_W-1:0];
	assign in_tag   = TAG_W'(tag_full);

	assign ram_we    = clearing_q || s1_fire;
	assign ram_waddr = clearing_q ? clr_idx_q : idx_s1;
	assign ram_wdata = clearing_q ? '0 : ROW_W'(wr_row);

	salru_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	assign cur_row = fwd_s1 ? fwd_row_s1 : row_t'(ram_rdata);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			stamps[w] = cur_row[w].stamp;
		end
	end

	salru_victim #(
		.WAYS (WAYS)
	) u_victim (
		.stamps (stamps),
		.victim (victim)
	);

	always_comb begin
		lk_hit  = 1'b0;
		hit_way = '0;
		inv_any = 1'b0;
		inv_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (cur_row[w].valid && (cur_row[w].tag == tag_s1)) begin
				lk_hit  = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!cur_row[w].valid) begin
				inv_any = 1'b1;
				inv_way = WAY_W'(w);
			end
		end
	end

	assign stamp_nx = use_stamp_q + 1'b1;
	assign sel_way  = lk_hit ? hit_way : (inv_any ? inv_way : victim);
	assign dirty_ev = !lk_hit && !inv_any && cur_row[victim].dirty;

	always_comb begin
		wr_row = cur_row;
		wr_row[sel_way].stamp = stamp_nx;
		if (lk_hit) begin
			wr_row[sel_way].dirty = cur_row[sel_way].dirty | func_s1;
		end else begin
			wr_row[sel_way].valid = 1'b1;
			wr_row[sel_way].dirty = func_s1;
			wr_row[sel_way].tag   = tag_s1;
		end
	end

	assign added = ADDED_W'(icount_s1)
		+ (lk_hit ? '0 : ADDED_W'(penalty_q) + BLOCK_ADD)
		+ (dirty_ev ? WRITEBACK_COST : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q    <= MISS_PENALTY_RST;
			use_stamp_q  <= '0;
			cycle_sum_q  <= '0;
			instr_sum_q  <= '0;
			access_sum_q <= '0;
			miss_sum_q   <= '0;
			clearing_q   <= 1'b1;
			clr_idx_q    <= '0;
			valid_s1     <= 1'b0;
			fwd_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				penalty_q <= cfg_penalty;
			end

			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == IDX_W'(ROWS - 1)) begin
					clearing_q <= 1'b0;
				end
			end

			if (in_accept) begin
				valid_s1 <= 1'b1;
				// same set written back this edge: the RAM read returns the old row
				fwd_s1   <= s1_fire && (in_idx == idx_s1);
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			if (s1_fire) begin
				use_stamp_q  <= stamp_nx;
				cycle_sum_q  <= cycle_sum_q + 48'(added);
				instr_sum_q  <= instr_sum_q + 32'(icount_s1);
				access_sum_q <= access_sum_q + 32'd1;
				if (!lk_hit) begin
					miss_sum_q <= miss_sum_q + 32'd1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1    <= func;
			idx_s1     <= in_idx;
			tag_s1     <= in_tag;
			icount_s1  <= instr_count;
			fwd_row_s1 <= wr_row;
		end
		if (s1_fire) begin
			hit_q   <= lk_hit;
			way_q   <= sel_way[0];
			dev_q   <= dirty_ev;
			added_q <= added;
		end
	end

	assign out_valid          = out_valid_q;
	assign hit                = hit_q;
	assign way_used           = way_q;
	assign dirty_eviction     = dev_q;
	assign cycles_added       = added_q;
	assign total_cycles       = cycle_sum_q;
	assign total_instructions = instr_sum_q;
	assign access_total       = access_sum_q;
	assign miss_total         = miss_sum_q;

endmodule

FILE: bench/set_assoc_lru_writeback_cache_unit_tb.sv
module set_assoc_lru_writeback_cache_unit_tb import salru_pkg::*;;

	localparam int N_WAYS = 2;
	localparam int BLOCK_SZ = 32;
	localparam int N_SETS = 512;
	localparam int OFF_W = 5;
	localparam int SET_W = 9;
	localparam int TAG_W = 32 - OFF_W - SET_W;
	localparam int N_LINES = N_SETS * N_WAYS;
	// miss cost adder for 32-byte lines
	localparam logic [ADDED_W-1:0] LINE_FILL_ADDER = 18'd2;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS = 250;

	typedef enum logic {ACC_LOAD = 1'b0, ACC_STORE = 1'b1} access_kind_t;

	typedef struct packed {
		logic               hit;
		logic               way;
		logic               dirty_ev;
		logic [ADDED_W-1:0] added;
		logic [47:0]        cycles;
		logic [31:0]        instrs;
		logic [31:0]        accesses;
		logic [31:0]        misses;
	} cache_result_t;

	class cache_timing_scoreboard;
		logic [PENALTY_W-1:0] penalty;
		bit                   line_valid [N_LINES];
		bit                   line_dirty [N_LINES];
		logic [TAG_W-1:0]     line_tag [N_LINES];
		logic [STAMP_W-1:0]   line_stamp [N_LINES];
		logic [STAMP_W-1:0]   stamp;
		logic [47:0]          cycle_sum;
		logic [31:0]          instr_sum;
		logic [31:0]          access_sum;
		logic [31:0]          miss_sum;
		cache_result_t        expected_q [$];
		int                   errors;
		int                   reported;
		int                   n_hits;
		int                   n_dirty_ev;
		int                   n_checked;

		function new();
			penalty = MISS_PENALTY_RST;
			foreach (line_valid[i]) begin
				line_valid[i] = 0;
				line_dirty[i] = 0;
				line_tag[i] = '0;
				line_stamp[i] = '0;
			end
			stamp = '0;
			cycle_sum = '0;
			instr_sum = '0;
			access_sum = '0;
			miss_sum = '0;
			errors = 0;
			reported = 0;
			n_hits = 0;
			n_dirty_ev = 0;
			n_checked = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_access(input logic st, input logic [31:0] a, input logic [15:0] n);
			cache_result_t    r;
			int               base;
			int               way;
			bit               found;
			logic [TAG_W-1:0] tg;

			tg = a[31:OFF_W+SET_W];
			base = int'(a[OFF_W+SET_W-1:OFF_W]) * N_WAYS;
			stamp = stamp + 1;
			access_sum = access_sum + 1;
			instr_sum = instr_sum + n;
			r = '0;
			r.added = ADDED_W'(n);
			way = 0;
			found = 0;
			for (int w = 0; w < N_WAYS; w++) begin
				if (!found && line_valid[base+w] && line_tag[base+w] == tg) begin
					found = 1;
					way = w;
				end
			end
			if (found) begin
				r.hit = 1'b1;
				line_stamp[base+way] = stamp;
				if (st == ACC_STORE)
					line_dirty[base+way] = 1;
				n_hits++;
			end else begin
				miss_sum = miss_sum + 1;
				for (int w = N_WAYS - 1; w >= 0; w--) begin
					if (!line_valid[base+w]) begin
						found = 1;
						way = w;
					end
				end
				if (!found) begin
					// LRU victim, lowest way wins a tie
					way = 0;
					for (int w = 1; w < N_WAYS; w++)
						if (line_stamp[base+w] < line_stamp[base+way])
							way = w;
					if (line_dirty[base+way]) begin
						r.dirty_ev = 1'b1;
						r.added = r.added + WRITEBACK_COST;
						n_dirty_ev++;
					end
				end
				line_tag[base+way] = tg;
				line_valid[base+way] = 1;
				line_dirty[base+way] = (st == ACC_STORE);
				line_stamp[base+way] = stamp;
				r.added = r.added + ADDED_W'(penalty) + LINE_FILL_ADDER;
			end
			cycle_sum = cycle_sum + 48'(r.added);
			r.way = way[0];
			r.cycles = cycle_sum;
			r.instrs = instr_sum;
			r.accesses = access_sum;
			r.misses = miss_sum;
			expected_q.push_back(r);
		endfunction

		function void flag(input string what);
			errors++;
			if (reported < 10) begin
				reported++;
				$display("[%0t] mismatch: %s", $realtime, what);
			end
		endfunction

		function void check_field(input string name, input logic [47:0] exp_v,
				input logic [47:0] act_v);
			if (exp_v !== act_v)
				flag($sformatf("beat %0d %s expected 0x%0h got 0x%0h",
					n_checked, name, exp_v, act_v));
		endfunction

		function void check_result(input cache_result_t got);
			cache_result_t exp_r;
			if (expected_q.size() == 0) begin
				flag("result beat with nothing outstanding");
				return;
			end
			exp_r = expected_q.pop_front();
			check_field("hit", 48'(exp_r.hit), 48'(got.hit));
			check_field("way_used", 48'(exp_r.way), 48'(got.way));
			check_field("dirty_eviction", 48'(exp_r.dirty_ev), 48'(got.dirty_ev));
			check_field("cycles_added", 48'(exp_r.added), 48'(got.added));
			check_field("total_cycles", exp_r.cycles, got.cycles);
			check_field("total_instructions", 48'(exp_r.instrs), 48'(got.instrs));
			check_field("access_total", 48'(exp_r.accesses), 48'(got.accesses));
			check_field("miss_total", 48'(exp_r.misses), 48'(got.misses));
			n_checked++;
		endfunction

		function void finish_check();
			if (expected_q.size() != 0)
				flag($sformatf("%0d results never came", expected_q.size()));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [PENALTY_W-1:0] cfg_penalty = MISS_PENALTY_RST;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = ACC_LOAD;
	logic [31:0]          address = '0;
	logic [15:0]          instr_count = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 hit;
	logic                 way_used;
	logic                 dirty_eviction;
	logic [ADDED_W-1:0]   cycles_added;
	logic [47:0]          total_cycles;
	logic [31:0]          total_instructions;
	logic [31:0]          access_total;
	logic [31:0]          miss_total;

	cache_timing_scoreboard sb;
	cache_result_t          seen;
	int                     idle_cycles = 0;
	bit                     beat_seen;
	int                     stall_mode = 0;
	logic [3:0]             stall_phase = '0;
	int                     burst_left = 0;
	int                     n_settings = 0;
	logic [SET_W-1:0]       hot_set [8];
	logic [TAG_W-1:0]       hot_tag [8];
	int                     n_hot_sets;
	int                     n_hot_tags;

	set_assoc_lru_writeback_cache_unit #(
		.WAYS(N_WAYS),
		.BLOCK_BYTES(BLOCK_SZ),
		.SETS(N_SETS),
		.ADDR_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_penalty(cfg_penalty),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.address(address),
		.instr_count(instr_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.way_used(way_used),
		.dirty_eviction(dirty_eviction),
		.cycles_added(cycles_added),
		.total_cycles(total_cycles),
		.total_instructions(total_instructions),
		.access_total(access_total),
		.miss_total(miss_total)
	);

	always #4 clk = ~clk;

	// receiver stall pattern, selected per phase
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		case (stall_mode)
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 6);
			3: out_stall <= (stall_phase[2:0] >= 3'd5);
			default: out_stall <= 1'b0;
		endcase
	end

	// beat monitor: note the access before checking, so ordering within a step is moot
	always @(posedge clk) begin
		if (arst_n) begin
			beat_seen = 0;
			if (in_valid && !in_stall) begin
				sb.note_access(func, address, instr_count);
				beat_seen = 1;
			end
			if (out_valid && !out_stall) begin
				seen.hit = hit;
				seen.way = way_used;
				seen.dirty_ev = dirty_eviction;
				seen.added = cycles_added;
				seen.cycles = total_cycles;
				seen.instrs = total_instructions;
				seen.accesses = access_total;
				seen.misses = miss_total;
				sb.check_result(seen);
				beat_seen = 1;
			end
			if (cfg_valid && cfg_ready)
				beat_seen = 1;
			idle_cycles = beat_seen ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic logic [31:0] make_addr(input logic [TAG_W-1:0] tg,
			input logic [SET_W-1:0] s, input logic [OFF_W-1:0] off);
		return {tg, s, off};
	endfunction

	task automatic send_access(input logic st, input logic [31:0] a, input logic [15:0] n);
		in_valid <= 1'b1;
		func <= st;
		address <= a;
		instr_count <= n;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_penalty(input logic [PENALTY_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_penalty <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.penalty = v;
		n_settings++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic run_directed();
		logic [SET_W-1:0] s;
		s = 9'h0A5;
		// fill both ways, then walk LRU victims through clean and dirty lines
		send_access(ACC_LOAD, make_addr(18'h00001, s, 5'd0), 16'd0);
		send_access(ACC_LOAD, make_addr(18'h3FFFF, s, 5'd4), 16'hFFFF);
		send_access(ACC_STORE, make_addr(18'h00001, s, 5'd31), 16'd3);
		send_access(ACC_LOAD, make_addr(18'h00001, s, 5'd8), 16'd1);
		send_access(ACC_LOAD, make_addr(18'h00002, s, 5'd0), 16'd2);
		send_access(ACC_LOAD, make_addr(18'h00003, s, 5'd0), 16'd0);
		send_access(ACC_STORE, make_addr(18'h00004, s, 5'd16), 16'd7);
		send_access(ACC_LOAD, make_addr(18'h00005, s, 5'd0), 16'hFFFF);
		send_access(ACC_LOAD, make_addr(18'h00006, s, 5'd0), 16'd0);
		send_access(ACC_STORE, make_addr(18'h00006, s, 5'd2), 16'd5);
		send_access(ACC_STORE, make_addr(18'h00005, s, 5'd2), 16'd5);
		send_access(ACC_LOAD, make_addr(18'h00007, s, 5'd0), 16'd9);
		// address extremes
		send_access(ACC_LOAD, 32'h0000_0000, 16'd0);
		send_access(ACC_STORE, 32'hFFFF_FFFF, 16'hFFFF);
		send_access(ACC_STORE, 32'h0000_0000, 16'd1);
		send_access(ACC_LOAD, 32'hFFFF_FFE0, 16'd0);
		send_access(ACC_LOAD, 32'h0000_3FE0, 16'd4);
		send_access(ACC_STORE, 32'hFFFF_C000, 16'd2);
		send_access(ACC_LOAD, 32'hAAAA_AAAA, 16'hAAAA);
		send_access(ACC_STORE, 32'h5555_5555, 16'h5555);
		send_access(ACC_LOAD, 32'hFFFF_FFFF, 16'd0);
		send_access(ACC_LOAD, 32'h0000_0000, 16'hFFFF);
		drain_results();
	endtask

	task automatic run_random(input int items, input int gap_max, input bit mid_drain);
		logic [31:0] a;
		logic [15:0] n;
		n_hot_sets = $urandom_range(1, 6);
		n_hot_tags = $urandom_range(2, 5);
		foreach (hot_set[i]) hot_set[i] = SET_W'($urandom);
		foreach (hot_tag[i]) hot_tag[i] = TAG_W'($urandom);
		hot_tag[0] = '1;
		burst_left = 0;
		for (int i = 0; i < items; i++) begin
			if (mid_drain && i == items / 2)
				drain_results();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if (gap_max > 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, gap_max)) @(posedge clk);
				end
			end
			// mostly a few hot sets with at least as many tags as ways, some fully random
			if ($urandom_range(0, 4) == 0)
				a = $urandom;
			else
				a = make_addr(hot_tag[$urandom_range(0, n_hot_tags - 1)],
					hot_set[$urandom_range(0, n_hot_sets - 1)], OFF_W'($urandom));
			case ($urandom_range(0, 9))
				0: n = 16'd0;
				1: n = 16'hFFFF;
				2, 3, 4: n = 16'($urandom);
				default: n = 16'($urandom_range(0, 50));
			endcase
			send_access($urandom_range(0, 1) ? ACC_STORE : ACC_LOAD, a, n);
			burst_left--;
		end
		drain_results();
	endtask

	initial begin
		logic [PENALTY_W-1:0] penalties [7];
		sb = new();
		penalties[0] = 16'd0;
		penalties[1] = 16'hFFFF;
		penalties[2] = 16'($urandom);
		penalties[3] = 16'd1;
		penalties[4] = 16'hFFFE;
		penalties[5] = 16'($urandom);
		penalties[6] = MISS_PENALTY_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs on the reset penalty, back to back
		run_directed();

		for (int p = 0; p < 7; p++) begin
			write_penalty(penalties[p]);
			stall_mode = p % 4;
			run_random(PHASE_ITEMS, (p == 0 || p == 4) ? 0 : 4 + 3 * p, p == 3);
		end
		stall_mode = 0;

		repeat (20) @(posedge clk);
		sb.finish_check();
		$display("covered %0d accesses: %0d hits, %0d misses, %0d dirty evictions",
			sb.n_checked, sb.n_hits, sb.n_checked - sb.n_hits, sb.n_dirty_ev);
		$display("%0d miss penalty writes plus reset value, %0d check errors",
			n_settings, sb.errors);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
